[hw/rtl/hkp_pkg.sv]
// types and constants shared by the keyboard new-press detector
`timescale 1ns / 1ps

package hkp_pkg;

    localparam int REPORT_SLOTS = 6;
    localparam logic [6:0] MIN_REPORT_BYTES = 7'd8;
    localparam logic [7:0] HIGHEST_RESERVED_CODE = 8'd3;

    typedef struct packed {
        logic [6:0] report_length;
        logic [7:0] modifier_bits;
        logic [7:0] slot_zero;
        logic [7:0] slot_one;
        logic [7:0] slot_two;
        logic [7:0] slot_three;
        logic [7:0] slot_four;
        logic [7:0] slot_five;
    } in_word_t;

    typedef struct packed {
        logic [7:0] pressed_code;
        logic [7:0] press_modifier;
        logic       last_press;
    } out_word_t;

    typedef logic [REPORT_SLOTS-1:0][7:0] slot_codes_t;

    // one report's new presses, handed from the detector to the emitter
    typedef struct packed {
        logic                    valid;
        logic [REPORT_SLOTS-1:0] mask;
        slot_codes_t             codes;
        logic [7:0]              modifier;
    } press_batch_t;

endpackage

[hw/rtl/hkp_detect.sv]
// input register, stored keys and new-press compare
`timescale 1ns / 1ps

module hkp_detect #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hkp_pkg::in_word_t     s_word,
    output hkp_pkg::press_batch_t batch,
    input  logic                  batch_ready
);
    import hkp_pkg::*;

    localparam int ACTIVE_SLOTS = (KEY_SLOTS < REPORT_SLOTS) ? KEY_SLOTS : REPORT_SLOTS;

    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic [7:0]  prior_keys_reg [ACTIVE_SLOTS];

    slot_codes_t             slots;
    logic [REPORT_SLOTS-1:0] new_mask;
    logic                    short_report;
    logic                    advance;
    logic                    load;

    always_comb begin
        slots[0] = in_word_reg.slot_zero;
        slots[1] = in_word_reg.slot_one;
        slots[2] = in_word_reg.slot_two;
        slots[3] = in_word_reg.slot_three;
        slots[4] = in_word_reg.slot_four;
        slots[5] = in_word_reg.slot_five;
    end

    always_comb begin
        logic held;
        new_mask = '0;
        for (int i = 0; i < ACTIVE_SLOTS; i++) begin
            held = 1'b0;
            for (int j = 0; j < ACTIVE_SLOTS; j++) begin
                held = held | (prior_keys_reg[j] == slots[i]);
            end
            new_mask[i] = (slots[i] > HIGHEST_RESERVED_CODE) && !held;
        end
    end

    assign short_report = in_word_reg.report_length < MIN_REPORT_BYTES;
    // short words drop out without touching the stored keys
    assign advance = in_valid_reg && (short_report || batch_ready);
    assign load    = in_valid_reg && !short_report && batch_ready;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        batch.valid    = in_valid_reg && !short_report;
        batch.mask     = new_mask;
        batch.codes    = slots;
        batch.modifier = in_word_reg.modifier_bits;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ACTIVE_SLOTS; k++) begin
                prior_keys_reg[k] <= 8'd0;
            end
        end else if (load) begin
            for (int k = 0; k < ACTIVE_SLOTS; k++) begin
                prior_keys_reg[k] <= slots[k];
            end
        end
    end

endmodule

[hw/rtl/hkp_emit.sv]
// serializes one report's new presses into the result register
`timescale 1ns / 1ps

module hkp_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hkp_pkg::press_batch_t batch,
    output logic                  batch_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hkp_pkg::out_word_t    m_word
);
    import hkp_pkg::*;

    logic [REPORT_SLOTS-1:0] pend_mask_reg, pend_mask_next;
    slot_codes_t             codes_reg;
    logic [7:0]              modifier_reg;
    logic                    m_valid_reg, m_valid_next;
    out_word_t               m_word_reg;

    logic [REPORT_SLOTS-1:0] lowest;
    logic [REPORT_SLOTS-1:0] rest;
    logic [7:0]              pick_code;
    logic                    out_free;
    logic                    emit_fire;
    logic                    take;

    // lowest pending slot goes first
    assign lowest = pend_mask_reg & (~pend_mask_reg + 1'b1);
    assign rest   = pend_mask_reg & ~lowest;

    always_comb begin
        pick_code = 8'd0;
        for (int i = 0; i < REPORT_SLOTS; i++) begin
            pick_code = pick_code | (codes_reg[i] & {8{lowest[i]}});
        end
    end

    assign out_free    = !m_valid_reg || m_ready;
    assign emit_fire   = out_free && (pend_mask_reg != '0);
    assign batch_ready = (pend_mask_reg == '0) || (emit_fire && (rest == '0));
    assign take        = batch.valid && batch_ready;

    always_comb begin
        pend_mask_next = pend_mask_reg;
        if (take) begin
            pend_mask_next = batch.mask;
        end else if (emit_fire) begin
            pend_mask_next = rest;
        end
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_mask_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            pend_mask_reg <= pend_mask_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            codes_reg    <= batch.codes;
            modifier_reg <= batch.modifier;
        end
        if (emit_fire) begin
            m_word_reg.pressed_code   <= pick_code;
            m_word_reg.press_modifier <= modifier_reg;
            m_word_reg.last_press     <= (rest == '0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

[hw/rtl/hid_keyboard_new_press_detect.sv]
// top level of the keyboard new-press detector
//
//  channel | dir | handshake         | word
//  s_      | in  | s_valid / s_ready | report length, modifier, six key slots
//  m_      | out | m_valid / m_ready | pressed code, modifier, last press mark
//
// a report is held in the input register and then in the pending registers; its new
// presses leave through the result register at one per cycle while m_ready does not stall
// stored keys clear on synchronous reset; short reports drop at the input register
// a stalled m_ready holds the result register and backs up into s_ready
`timescale 1ns / 1ps

module hid_keyboard_new_press_detect #(
    parameter int KEY_SLOTS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hkp_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output hkp_pkg::out_word_t m_word
);
    import hkp_pkg::*;

    press_batch_t batch;
    logic         batch_ready;

    hkp_detect #(
        .KEY_SLOTS(KEY_SLOTS)
    ) u_detect (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .batch      (batch),
        .batch_ready(batch_ready)
    );

    hkp_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .batch      (batch),
        .batch_ready(batch_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

endmodule

[tb/sv/tb.sv]
// testbench for the keyboard new-press detector: directed rows, typing traffic, press scoreboard
`timescale 1ns / 1ps

module tb;
    import hkp_pkg::*;

    localparam int KEY_SLOTS    = 6;
    localparam int ACTIVE_SLOTS = (KEY_SLOTS < REPORT_SLOTS) ? KEY_SLOTS : REPORT_SLOTS;
    localparam int RANDOM_PER_PHASE = 72;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        in_word_t  word;
        bit        typed;
        bit        typed_has;
        out_word_t typed_res;
    } press_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    // predictor state
    logic [7:0] stored_keys [ACTIVE_SLOTS];
    out_word_t  fresh_press [REPORT_SLOTS];
    out_word_t  press_exp_q [$];
    // typing model for random traffic
    logic [7:0] typing_held [REPORT_SLOTS];

    press_row_t directed_rows [$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_granted   = 0;
    int hold_left      = 0;
    int mismatch_cnt   = 0;
    int cycle_cnt      = 0;

    hid_keyboard_new_press_detect #(
        .KEY_SLOTS(KEY_SLOTS)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_word (s_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_word (m_word)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic in_word_t make_report(input logic [6:0] len, input logic [7:0] modi,
                                             input logic [7:0] s0, input logic [7:0] s1,
                                             input logic [7:0] s2, input logic [7:0] s3,
                                             input logic [7:0] s4, input logic [7:0] s5);
        in_word_t w;
        w.report_length = len;
        w.modifier_bits = modi;
        w.slot_zero     = s0;
        w.slot_one      = s1;
        w.slot_two      = s2;
        w.slot_three    = s3;
        w.slot_four     = s4;
        w.slot_five     = s5;
        return w;
    endfunction

    function automatic out_word_t make_press(input logic [7:0] code, input logic [7:0] modi,
                                             input logic last);
        out_word_t r;
        r.pressed_code   = code;
        r.press_modifier = modi;
        r.last_press     = last;
        return r;
    endfunction

    function automatic void add_row(input in_word_t w);
        press_row_t r;
        r.word      = w;
        r.typed     = 1'b0;
        r.typed_has = 1'b0;
        r.typed_res = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_typed(input in_word_t w, input bit has, input out_word_t res);
        press_row_t r;
        r.word      = w;
        r.typed     = 1'b1;
        r.typed_has = has;
        r.typed_res = res;
        directed_rows.push_back(r);
    endfunction

    // fills fresh_press with the new presses of one report and updates the stored keys
    function automatic int predict_presses(input in_word_t w);
        logic [7:0] slots [REPORT_SLOTS];
        int n;
        bit held;
        n = 0;
        if (w.report_length < MIN_REPORT_BYTES) return 0;
        slots[0] = w.slot_zero;
        slots[1] = w.slot_one;
        slots[2] = w.slot_two;
        slots[3] = w.slot_three;
        slots[4] = w.slot_four;
        slots[5] = w.slot_five;
        for (int i = 0; i < ACTIVE_SLOTS; i++) begin
            held = 1'b0;
            for (int j = 0; j < ACTIVE_SLOTS; j++) begin
                if (stored_keys[j] == slots[i]) held = 1'b1;
            end
            if (slots[i] > HIGHEST_RESERVED_CODE && !held) begin
                fresh_press[n] = make_press(slots[i], w.modifier_bits, 1'b0);
                n++;
            end
        end
        if (n > 0) fresh_press[n-1].last_press = 1'b1;
        for (int i = 0; i < ACTIVE_SLOTS; i++) stored_keys[i] = slots[i];
        return n;
    endfunction

    // mostly a typing session: keys go down and up a few at a time, plus noise
    function automatic in_word_t next_typing_report();
        logic [7:0] s [REPORT_SLOTS];
        logic [6:0] len;
        int roll;
        for (int i = 0; i < REPORT_SLOTS; i++) begin
            if ($urandom_range(99) < 30) begin
                case ($urandom_range(3))
                    0: begin
                        typing_held[i] = 8'h00;
                    end
                    1, 2: begin
                        typing_held[i] = 8'($urandom_range(15, 0));
                    end
                    default: begin
                        typing_held[i] = 8'($urandom_range(255, 0));
                    end
                endcase
            end
            s[i] = typing_held[i];
        end
        if ($urandom_range(99) < 10) begin
            for (int i = 0; i < REPORT_SLOTS; i++) s[i] = 8'($urandom_range(255, 0));
        end
        roll = $urandom_range(99);
        if (roll < 8)       len = 7'($urandom_range(7, 0));
        else if (roll < 11) len = 7'($urandom_range(127, 65));
        else if (roll < 50) len = MIN_REPORT_BYTES;
        else                len = 7'($urandom_range(64, 8));
        return make_report(len, 8'($urandom_range(255, 0)), s[0], s[1], s[2], s[3], s[4], s[5]);
    endfunction

    function automatic void note_miss(input string what, input int exp_v, input int act_v);
        if (mismatch_cnt < 10)
            $display("press mismatch %s: expected %0h got %0h at %0t", what, exp_v, act_v,
                     $realtime);
        mismatch_cnt++;
    endfunction

    function automatic void check_press(input out_word_t got);
        out_word_t want;
        if (press_exp_q.size() == 0) begin
            if (mismatch_cnt < 10)
                $display("unexpected press word code %0h mod %0h last %0b at %0t",
                         got.pressed_code, got.press_modifier, got.last_press, $realtime);
            mismatch_cnt++;
            return;
        end
        want = press_exp_q.pop_front();
        if (got.pressed_code !== want.pressed_code)
            note_miss("pressed_code", want.pressed_code, got.pressed_code);
        if (got.press_modifier !== want.press_modifier)
            note_miss("press_modifier", want.press_modifier, got.press_modifier);
        if (got.last_press !== want.last_press)
            note_miss("last_press", want.last_press, got.last_press);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_press(m_word);
    end

    // receiver side: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_granted != hold_asked) begin
            hold_left    = HOLD_CYCLES;
            hold_granted = hold_asked;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_report(input press_row_t r);
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= r.word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n = predict_presses(r.word);
        if (r.typed) begin
            if (r.typed_has) press_exp_q.push_back(r.typed_res);
        end else begin
            for (int i = 0; i < n; i++) press_exp_q.push_back(fresh_press[i]);
        end
        @(negedge aclk);
    endtask

    initial begin
        press_row_t r;
        int sent;
        for (int i = 0; i < ACTIVE_SLOTS; i++) stored_keys[i] = 8'h00;
        for (int i = 0; i < REPORT_SLOTS; i++) typing_held[i] = 8'h00;

        // rows right after reset, results read off directly
        add_typed(make_report(7'd8, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                  1'b1, make_press(8'h04, 8'h00, 1'b1));
        // short report ignored
        add_typed(make_report(7'd7, 8'h5A, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15),
                  1'b0, '0);
        add_typed(make_report(7'd64, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                  1'b1, make_press(8'hFF, 8'hFF, 1'b1));
        // reserved codes only
        add_typed(make_report(7'd8, 8'h00, 8'h01, 8'h02, 8'h03, 8'h00, 8'h01, 8'h02),
                  1'b0, '0);
        add_typed(make_report(7'd0, 8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA),
                  1'b0, '0);
        add_typed(make_report(7'd8, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04),
                  1'b1, make_press(8'h04, 8'h81, 1'b1));
        // predicted rows
        add_row(make_report(7'd8, 8'h02, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15));
        add_row(make_report(7'd8, 8'h02, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15));
        add_row(make_report(7'd8, 8'h20, 8'h20, 8'h20, 8'h10, 8'h11, 8'h12, 8'h13));
        add_row(make_report(7'd9, 8'h01, 8'h03, 8'h20, 8'h04, 8'h11, 8'h00, 8'h13));
        add_row(make_report(7'd8, 8'h03, 8'h03, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00));
        add_row(make_report(7'd8, 8'h40, 8'h20, 8'h21, 8'h10, 8'h22, 8'h12, 8'h00));
        add_row(make_report(7'd127, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        add_row(make_report(7'd127, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        add_row(make_report(7'd9, 8'hAA, 8'h04, 8'h05, 8'hFE, 8'hFD, 8'hFC, 8'hFB));
        add_row(make_report(7'd7, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
        add_row(make_report(7'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        add_row(make_report(7'd63, 8'h55, 8'hAA, 8'h55, 8'hCC, 8'h33, 8'hF0, 8'h0F));
        add_row(make_report(7'd8, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h55, 8'hAA));
        add_row(make_report(7'd8, 8'h00, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04));
        add_row(make_report(7'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[k]) offer_report(directed_rows[k]);

        r.typed     = 1'b0;
        r.typed_has = 1'b0;
        r.typed_res = '0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // long receiver hold-off while the sender keeps pushing
                    hold_asked++;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                r.word = next_typing_report();
                offer_report(r);
                sent++;
            end
        end

        s_valid <= 1'b0;
        while (press_exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && press_exp_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/hkp_pkg.sv
hw/rtl/hkp_detect.sv
hw/rtl/hkp_emit.sv
hw/rtl/hid_keyboard_new_press_detect.sv
tb/sv/tb.sv
